>>> src/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg
// shared types and constants of the pid controller with integral clamp
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned FracW = 16;
  localparam int unsigned GainW = WordW - 1;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegGainP = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainI = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainD = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLimit = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTarget = 3'd4;

  localparam logic [GainW-1:0] GainPRst = 31'd5636;
  localparam logic [GainW-1:0] GainIRst = 31'd576;
  localparam logic [GainW-1:0] GainDRst = 31'd12255;
  localparam logic [GainW-1:0] LimitRst = 31'd642253;
  localparam logic [WordW-1:0] TargetRst = 32'hFFFD_8000;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CAPT,
    OP_MP,
    OP_MI,
    OP_IACC,
    OP_MQL,
    OP_MQH,
    OP_ACCHI,
    OP_CAPLD,
    OP_DSTEP,
    OP_CAPWB,
    OP_CQH,
    OP_IWB,
    OP_MD,
    OP_DLD,
    OP_DWB
  } op_e;

  typedef struct packed {
    op_e  op;
    logic dhold;
    logic sum;
  } cmd_t;

  typedef struct packed {
    logic iclip;
    logic dt_zero;
  } status_t;

endpackage

>>> src/pidaw_ctrl.sv
// ----------------------------------------------------------------------------
// pidaw_ctrl
// step sequencer: walks one sample through the datapath and owns the handshakes
// ----------------------------------------------------------------------------
module pidaw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  pidaw_pkg::status_t status_i,
  output pidaw_pkg::cmd_t    cmd_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MP     = 5'd1;
  localparam logic [4:0] S_MI     = 5'd2;
  localparam logic [4:0] S_IACC   = 5'd3;
  localparam logic [4:0] S_MQL    = 5'd4;
  localparam logic [4:0] S_MQH    = 5'd5;
  localparam logic [4:0] S_QCHK   = 5'd6;
  localparam logic [4:0] S_CHK    = 5'd7;
  localparam logic [4:0] S_CAPLD  = 5'd8;
  localparam logic [4:0] S_CAPDIV = 5'd9;
  localparam logic [4:0] S_CAPWB  = 5'd10;
  localparam logic [4:0] S_CQH    = 5'd11;
  localparam logic [4:0] S_CQS    = 5'd12;
  localparam logic [4:0] S_IWB    = 5'd13;
  localparam logic [4:0] S_MD     = 5'd14;
  localparam logic [4:0] S_DLD    = 5'd15;
  localparam logic [4:0] S_DDIV   = 5'd16;
  localparam logic [4:0] S_DWB    = 5'd17;
  localparam logic [4:0] S_DHOLD  = 5'd18;
  localparam logic [4:0] S_SUM    = 5'd19;

  logic [4:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '{op: pidaw_pkg::OP_NOP, dhold: 1'b0, sum: 1'b0};
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = pidaw_pkg::OP_CAPT;
          state_d  = S_MP;
        end
      end
      S_MP: begin
        cmd_o.op = pidaw_pkg::OP_MP;
        state_d  = S_MI;
      end
      S_MI: begin
        cmd_o.op = pidaw_pkg::OP_MI;
        state_d  = S_IACC;
      end
      S_IACC: begin
        cmd_o.op = pidaw_pkg::OP_IACC;
        state_d  = S_MQL;
      end
      S_MQL: begin
        cmd_o.op = pidaw_pkg::OP_MQL;
        state_d  = S_MQH;
      end
      S_MQH: begin
        cmd_o.op = pidaw_pkg::OP_MQH;
        state_d  = S_QCHK;
      end
      S_QCHK: begin
        cmd_o.op = pidaw_pkg::OP_ACCHI;
        state_d  = S_CHK;
      end
      S_CHK: begin
        state_d = status_i.iclip ? S_CAPLD : S_IWB;
      end
      S_CAPLD: begin
        cmd_o.op = pidaw_pkg::OP_CAPLD;
        cnt_d    = '0;
        state_d  = S_CAPDIV;
      end
      S_CAPDIV: begin
        cmd_o.op = pidaw_pkg::OP_DSTEP;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = S_CAPWB;
        end
      end
      S_CAPWB: begin
        cmd_o.op = pidaw_pkg::OP_CAPWB;
        state_d  = S_CQH;
      end
      S_CQH: begin
        cmd_o.op = pidaw_pkg::OP_CQH;
        state_d  = S_CQS;
      end
      S_CQS: begin
        cmd_o.op = pidaw_pkg::OP_ACCHI;
        state_d  = S_IWB;
      end
      S_IWB: begin
        cmd_o.op = pidaw_pkg::OP_IWB;
        state_d  = status_i.dt_zero ? S_DHOLD : S_MD;
      end
      S_MD: begin
        cmd_o.op = pidaw_pkg::OP_MD;
        state_d  = S_DLD;
      end
      S_DLD: begin
        cmd_o.op = pidaw_pkg::OP_DLD;
        cnt_d    = '0;
        state_d  = S_DDIV;
      end
      S_DDIV: begin
        cmd_o.op = pidaw_pkg::OP_DSTEP;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = S_DWB;
        end
      end
      S_DWB: begin
        cmd_o.op = pidaw_pkg::OP_DWB;
        state_d  = S_SUM;
      end
      S_DHOLD: begin
        cmd_o.dhold = 1'b1;
        state_d     = S_SUM;
      end
      S_SUM: begin
        // result register must be free before the new beat lands
        if (out_free) begin
          cmd_o.sum   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> src/pidaw_datapath.sv
// ----------------------------------------------------------------------------
// pidaw_datapath
// config registers, loop state, shared multiplier and radix-2 divider
// ----------------------------------------------------------------------------
module pidaw_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  pidaw_pkg::cmd_t                       cmd_i,
  output pidaw_pkg::status_t                    status_o,
  input  logic                                  cfg_we_i,
  input  logic [pidaw_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [pidaw_pkg::WordW-1:0]           cfg_data_i,
  input  logic [63:0]                           in_data_i,
  output logic [pidaw_pkg::WordW-1:0]           drive_o,
  output logic                                  clamped_o
);

  localparam int unsigned GW = pidaw_pkg::GainW;
  localparam int unsigned FW = pidaw_pkg::FracW;

  logic [GW-1:0] gain_p_q, gain_i_q, gain_d_q, limit_q;
  logic [31:0]   target_q;

  logic signed [63:0] integral_q;
  logic signed [31:0] last_err_q, last_deriv_q;
  logic [31:0]        last_time_q;

  logic signed [31:0] err_q;
  logic [31:0]        dt_q, time_q;
  logic [63:0]        prod_q;
  logic [95:0]        acc_q;
  logic signed [47:0] p_q;
  logic signed [31:0] i_q, d_q;
  logic [63:0]        num_q;
  logic [47:0]        den_q, rem_q;
  logic [31:0]        drive_q;
  logic               clamped_q;

  logic [31:0]        mul_a, mul_b;
  logic [31:0]        err_mag;
  logic [63:0]        int_mag;
  logic signed [32:0] diff;
  logic [31:0]        diff_mag;
  logic signed [32:0] err_wide;
  logic signed [31:0] err_sat;
  logic [63:0]        addend, int_sum;
  logic signed [63:0] int_next;
  logic [48:0]        rem_sh, rem_sub;
  logic [30:0]        q_lo;
  logic signed [48:0] sum;
  logic signed [48:0] lim_w;
  logic signed [31:0] d_sat;
  logic signed [63:0] cap_s;

  assign err_mag  = err_q[31] ? 32'(-err_q) : 32'(err_q);
  assign int_mag  = integral_q[63] ? 64'(-integral_q) : 64'(integral_q);
  assign diff     = 33'(err_q) - 33'(last_err_q);
  assign diff_mag = diff[32] ? 32'(-diff) : diff[31:0];

  // saturated error from the incoming beat
  assign err_wide = 33'(signed'(target_q)) - 33'(signed'(in_data_i[31:0]));
  always_comb begin
    if (err_wide[32] != err_wide[31]) begin
      err_sat = err_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      err_sat = err_wide[31:0];
    end
  end

  assign status_o.iclip   = (gain_i_q != '0) &&
                            ((acc_q[95:47] != '0) || (acc_q[46:16] > limit_q));
  assign status_o.dt_zero = (dt_q == '0);

  always_comb begin
    unique case (cmd_i.op)
      pidaw_pkg::OP_MP: begin
        mul_a = {1'b0, gain_p_q};
        mul_b = err_mag;
      end
      pidaw_pkg::OP_MI: begin
        mul_a = err_mag;
        mul_b = dt_q;
      end
      pidaw_pkg::OP_MQL: begin
        mul_a = int_mag[31:0];
        mul_b = {1'b0, gain_i_q};
      end
      pidaw_pkg::OP_MQH: begin
        mul_a = int_mag[63:32];
        mul_b = {1'b0, gain_i_q};
      end
      pidaw_pkg::OP_CAPWB: begin
        mul_a = num_q[31:0];
        mul_b = {1'b0, gain_i_q};
      end
      pidaw_pkg::OP_CQH: begin
        mul_a = num_q[63:32];
        mul_b = {1'b0, gain_i_q};
      end
      pidaw_pkg::OP_MD: begin
        mul_a = {1'b0, gain_d_q};
        mul_b = diff_mag;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // saturating accumulate of error times dt
  always_comb begin
    addend   = err_q[31] ? -prod_q : prod_q;
    int_sum  = 64'(integral_q) + addend;
    int_next = signed'(int_sum);
    if ((integral_q[63] == addend[63]) && (int_sum[63] != integral_q[63])) begin
      int_next = integral_q[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
  end

  assign rem_sh  = {rem_q, num_q[63]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign q_lo    = acc_q[46:16];
  assign cap_s   = integral_q[63] ? -signed'(num_q) : signed'(num_q);

  always_comb begin
    if (diff[32]) begin
      d_sat = (num_q > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-num_q[31:0]);
    end else begin
      d_sat = (num_q >= 64'h8000_0000) ? 32'sh7fff_ffff : signed'(num_q[31:0]);
    end
  end

  assign sum   = 49'(p_q) + 49'(i_q) + 49'(d_q);
  assign lim_w = signed'({18'd0, limit_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q     <= pidaw_pkg::GainPRst;
      gain_i_q     <= pidaw_pkg::GainIRst;
      gain_d_q     <= pidaw_pkg::GainDRst;
      limit_q      <= pidaw_pkg::LimitRst;
      target_q     <= pidaw_pkg::TargetRst;
      integral_q   <= '0;
      last_err_q   <= '0;
      last_deriv_q <= '0;
      last_time_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          pidaw_pkg::RegGainP:  gain_p_q <= cfg_data_i[GW-1:0];
          pidaw_pkg::RegGainI:  gain_i_q <= cfg_data_i[GW-1:0];
          pidaw_pkg::RegGainD:  gain_d_q <= cfg_data_i[GW-1:0];
          pidaw_pkg::RegLimit:  limit_q  <= cfg_data_i[GW-1:0];
          pidaw_pkg::RegTarget: target_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == pidaw_pkg::OP_IACC) begin
        integral_q <= int_next;
      end else if (cmd_i.op == pidaw_pkg::OP_CAPWB) begin
        integral_q <= cap_s;
      end
      if (cmd_i.sum) begin
        last_err_q   <= err_q;
        last_time_q  <= time_q;
        last_deriv_q <= d_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      pidaw_pkg::OP_MP, pidaw_pkg::OP_MQL, pidaw_pkg::OP_CAPWB,
      pidaw_pkg::OP_MD: begin
        prod_q <= mul_a * mul_b;
      end
      pidaw_pkg::OP_MI: begin
        p_q    <= err_q[31] ? -signed'({2'b00, prod_q[61:16]})
                            : signed'({2'b00, prod_q[61:16]});
        prod_q <= mul_a * mul_b;
      end
      pidaw_pkg::OP_MQH, pidaw_pkg::OP_CQH: begin
        acc_q  <= {32'd0, prod_q};
        prod_q <= mul_a * mul_b;
      end
      pidaw_pkg::OP_ACCHI: begin
        acc_q <= acc_q + {prod_q, 32'd0};
      end
      pidaw_pkg::OP_CAPT: begin
        err_q  <= err_sat;
        dt_q   <= in_data_i[63:32] - last_time_q;
        time_q <= in_data_i[63:32];
      end
      pidaw_pkg::OP_CAPLD: begin
        num_q <= {17'd0, limit_q, {FW{1'b0}}};
        den_q <= {17'd0, gain_i_q};
        rem_q <= '0;
      end
      pidaw_pkg::OP_DLD: begin
        num_q <= prod_q;
        den_q <= {dt_q, {FW{1'b0}}};
        rem_q <= '0;
      end
      pidaw_pkg::OP_DSTEP: begin
        if (!rem_sub[48]) begin
          rem_q <= rem_sub[47:0];
          num_q <= {num_q[62:0], 1'b1};
        end else begin
          rem_q <= rem_sh[47:0];
          num_q <= {num_q[62:0], 1'b0};
        end
      end
      pidaw_pkg::OP_IWB: begin
        i_q <= integral_q[63] ? -signed'({1'b0, q_lo}) : signed'({1'b0, q_lo});
      end
      pidaw_pkg::OP_DWB: begin
        d_q <= d_sat;
      end
      default: ;
    endcase
    if (cmd_i.dhold) begin
      d_q <= last_deriv_q;
    end
    if (cmd_i.sum) begin
      if (sum > lim_w) begin
        drive_q   <= {1'b0, limit_q};
        clamped_q <= 1'b1;
      end else if (sum < -lim_w) begin
        drive_q   <= 32'(-lim_w);
        clamped_q <= 1'b1;
      end else begin
        drive_q   <= sum[31:0];
        clamped_q <= 1'b0;
      end
    end
  end

  assign drive_o   = drive_q;
  assign clamped_o = clamped_q;

endmodule

>>> src/pid_controller_antiwindup_unit.sv
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_unit
// pid controller, signed Q16.16, with integral clamp anti-windup
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one sample per beat: measurement and millisecond timestamp.
//   m_axis returns one beat per sample: clamped drive and a clamp flag.
//   cfg_* writes gains, limit and set point; write only while idle.
// timing:
//   a sample runs the proportional, integral and derivative steps, plus the
//   integral cap steps when the integral is clamped, minus the derivative
//   steps when dt is zero (derivative held); the next sample can be taken in
//   the cycle after the drive beat is written. the steps share a 64-step
//   radix-2 divider (derivative quotient, integral cap) and a 32x32 multiplier.
//   a finished result waits in the output register; the next sample is taken
//   meanwhile, but no new result is written until the old one is taken.
// reset: gains, limit and set point return to their defaults, loop state to
//   zero, no output beat pending.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // measurement [31:0], time_ms [63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // drive [31:0]
  output logic        m_axis_tuser,   // clamped [0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  pidaw_pkg::cmd_t    cmd;
  pidaw_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  pidaw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pidaw_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .drive_o     (m_axis_tdata),
    .clamped_o   (m_axis_tuser)
  );

endmodule
